// ===== design/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// shared widths, codes and memory request type of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned CapacityDef = 8;
  localparam int unsigned DataW       = 64;
  localparam int unsigned PosW        = 8;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND      = 3'd0,
    CMD_INSERT      = 3'd1,
    CMD_INSERT_HEAD = 3'd2,
    CMD_REMOVE      = 3'd3,
    CMD_UPDATE      = 3'd4,
    CMD_READ        = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  typedef struct packed {
    logic             we;
    logic [PosW-1:0]  waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [PosW-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== design/pal_in_if.sv =====
// ----------------------------------------------------------------------------
// pal_in_if
// command channel: valid/ready with command, position and entry word
// ----------------------------------------------------------------------------
interface pal_in_if
  import pal_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [PosW-1:0]  position;
  logic [DataW-1:0] entry_data;

  modport source (output valid, output cmd, output position, output entry_data, input ready);
  modport sink (input valid, input cmd, input position, input entry_data, output ready);

endinterface

// ===== design/pal_out_if.sv =====
// ----------------------------------------------------------------------------
// pal_out_if
// result channel: valid/ready with status, read word and entry count
// ----------------------------------------------------------------------------
interface pal_out_if
  import pal_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [DataW-1:0]   read_data;
  logic [CountW-1:0]  count;

  modport source (output valid, output status, output read_data, output count, input ready);
  modport sink (input valid, input status, input read_data, input count, output ready);

endinterface

// ===== design/pal_mem.sv =====
// ----------------------------------------------------------------------------
// pal_mem
// entry storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pal_mem
  import pal_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [DataW-1:0] rdata_o
);

  localparam int unsigned IdxW = $clog2(Capacity);

  logic [DataW-1:0] mem_q [Capacity];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[IdxW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[IdxW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// command sequencer: checks, entry shifts through the memory, result register
// ----------------------------------------------------------------------------
module pal_ctrl
  import pal_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pal_in_if.sink           in_i,
  pal_out_if.source        out_o,
  output mem_req_t         mem_req_o,
  input  logic [DataW-1:0] mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHR,
    S_INS,
    S_SHL,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [DataW-1:0]   data_q, data_d;
  status_e            status_q, status_d;
  logic               rd_sel_q, rd_sel_d;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [DataW-1:0]   out_rdata_q, out_rdata_d;
  logic [CountW-1:0]  out_count_q, out_count_d;

  logic            full;
  logic            pos_ok;
  logic [IdxW-1:0] in_idx;
  logic [IdxW-1:0] last_idx;
  logic [IdxW-1:0] ins_idx;

  assign full     = count_q >= CntW'(Capacity);
  assign pos_ok   = (in_i.position != '0) && (in_i.position <= PosW'(count_q));
  assign in_idx   = IdxW'(in_i.position - PosW'(1));
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign ins_idx  = (in_i.cmd == CMD_INSERT_HEAD) ? '0 : in_idx;

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.read_data = out_rdata_q;
  assign out_o.count     = out_count_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    idx_d        = idx_q;
    data_d       = data_q;
    status_d     = status_q;
    rd_sel_d     = rd_sel_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_rdata_d  = out_rdata_q;
    out_count_d  = out_count_q;
    mem_req_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          status_d = ST_OK;
          rd_sel_d = 1'b0;
          data_d   = in_i.entry_data;
          state_d  = S_RESP;
          case (in_i.cmd)
            CMD_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = PosW'(count_q);
                mem_req_o.wdata = in_i.entry_data;
                count_d         = count_q + CntW'(1);
              end
            end
            CMD_INSERT, CMD_INSERT_HEAD: begin
              if (full) begin
                status_d = ST_FULL;
              end else if ((in_i.cmd == CMD_INSERT) && !pos_ok) begin
                status_d = ST_BADPOS;
              end else if (PosW'(ins_idx) == PosW'(count_q)) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = PosW'(ins_idx);
                mem_req_o.wdata = in_i.entry_data;
                count_d         = count_q + CntW'(1);
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = PosW'(last_idx);
                ptr_d           = last_idx;
                idx_d           = ins_idx;
                state_d         = S_SHR;
              end
            end
            CMD_REMOVE: begin
              if (!pos_ok) begin
                status_d = ST_BADPOS;
              end else if (in_idx == last_idx) begin
                count_d = count_q - CntW'(1);
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = PosW'(in_idx + IdxW'(1));
                ptr_d           = in_idx + IdxW'(1);
                state_d         = S_SHL;
              end
            end
            CMD_UPDATE: begin
              if (!pos_ok) begin
                status_d = ST_BADPOS;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = PosW'(in_idx);
                mem_req_o.wdata = in_i.entry_data;
              end
            end
            CMD_READ: begin
              if (!pos_ok) begin
                status_d = ST_BADPOS;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = PosW'(in_idx);
                rd_sel_d        = 1'b1;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_SHR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = PosW'(ptr_q + IdxW'(1));
        mem_req_o.wdata = mem_rdata_i;
        if (ptr_q == idx_q) begin
          state_d = S_INS;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = PosW'(ptr_q - IdxW'(1));
          ptr_d           = ptr_q - IdxW'(1);
        end
      end
      S_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = PosW'(idx_q);
        mem_req_o.wdata = data_q;
        count_d         = count_q + CntW'(1);
        state_d         = S_RESP;
      end
      S_SHL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = PosW'(ptr_q - IdxW'(1));
        mem_req_o.wdata = mem_rdata_i;
        if (ptr_q == last_idx) begin
          count_d = count_q - CntW'(1);
          state_d = S_RESP;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = PosW'(ptr_q + IdxW'(1));
          ptr_d           = ptr_q + IdxW'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_rdata_d  = rd_sel_q ? mem_rdata_i : '0;
          out_count_d  = CountW'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_sel_q    <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    idx_q        <= idx_d;
    data_q       <= data_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_rdata_q  <= out_rdata_d;
    out_count_q  <= out_count_d;
  end

endmodule

// ===== design/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// fixed-capacity ordered list of 64-bit entries held in a synchronous memory
// sequence: append, update, read and rejected commands go straight to the result
//   state; insert moves the entries at and after the position up, writes the new
//   entry, then gives the result; remove moves the later entries down first
// throughput: the next command is taken the cycle after the result is loaded,
//   one entry moved per cycle through the memory's single read/write port pair
// reset: count and handshake clear at once; memory contents are not cleared
// ----------------------------------------------------------------------------
module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pal_in_if.sink    in_i,
  pal_out_if.source out_o
);

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;

  pal_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  pal_mem #(
    .Capacity (Capacity)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
